FILE: sv/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared constants and types for the polyline point projection core
// Holds coordinate, product and quotient widths and the divider handshake
// structs used between the core and its arithmetic units.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int COORD_BITS   = 31;
	// internal point width: one spare bit so a rounded foot never wraps
	localparam int PT_W         = COORD_BITS + 1;
	localparam int DIFF_W       = PT_W + 1;
	localparam int MAG_W        = PT_W;
	localparam int PROD_W       = 2 * MAG_W;
	localparam int QUO_W        = MAG_W;
	localparam int OFS_W        = QUO_W + 1;

	localparam int MAX_VERTICES = 65536;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W        = $clog2(MAX_VERTICES);

	localparam int IN_FIELDS_W  = 4 * COORD_BITS;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * COORD_BITS + IDX_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	typedef struct packed {
		logic start;
		logic neg;
	} ppp_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ppp_div_rsp_t;

endpackage

FILE: sv/ppp_mul.sv
// ----------------------------------------------------------------------------
// ppp_mul: shared two-stage multiplier
// Stage one takes magnitudes and the product sign, stage two multiplies the
// magnitudes. The sign travels beside the unsigned product.
// ----------------------------------------------------------------------------
module ppp_mul (
	input  logic                                clk,
	input  logic signed [ppp_pkg::DIFF_W-1:0]   opa,
	input  logic signed [ppp_pkg::DIFF_W-1:0]   opb,
	output logic        [ppp_pkg::PROD_W-1:0]   prod,
	output logic                                neg
);

	logic [ppp_pkg::DIFF_W-1:0] abs_a;
	logic [ppp_pkg::DIFF_W-1:0] abs_b;
	logic [ppp_pkg::MAG_W-1:0]  mag_a_s1;
	logic [ppp_pkg::MAG_W-1:0]  mag_b_s1;
	logic                       neg_s1;
	logic [ppp_pkg::PROD_W-1:0] prod_s2;
	logic                       neg_s2;

	assign abs_a = opa[ppp_pkg::DIFF_W-1] ? ppp_pkg::DIFF_W'(-opa) : ppp_pkg::DIFF_W'(opa);
	assign abs_b = opb[ppp_pkg::DIFF_W-1] ? ppp_pkg::DIFF_W'(-opb) : ppp_pkg::DIFF_W'(opb);

	always_ff @(posedge clk) begin
		mag_a_s1 <= abs_a[ppp_pkg::MAG_W-1:0];
		mag_b_s1 <= abs_b[ppp_pkg::MAG_W-1:0];
		neg_s1   <= opa[ppp_pkg::DIFF_W-1] ^ opb[ppp_pkg::DIFF_W-1];
		prod_s2  <= mag_a_s1 * mag_b_s1;
		neg_s2   <= neg_s1;
	end

	assign prod = prod_s2;
	assign neg  = neg_s2;

endmodule

FILE: sv/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div: restoring divider with round-half rule for the foot offset
// Divides (num_hi:num_lo) by den one quotient bit per cycle, then rounds the
// quotient toward the nearest integer and applies the sign.
// ----------------------------------------------------------------------------
module ppp_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ppp_pkg::ppp_div_req_t               req,     // start, neg
	input  logic        [ppp_pkg::PROD_W-1:0]   num_hi,  // initial remainder
	input  logic        [ppp_pkg::QUO_W-1:0]    num_lo,  // bits shifted in
	input  logic        [ppp_pkg::PROD_W-1:0]   den,
	output ppp_pkg::ppp_div_rsp_t               rsp,     // done, busy
	output logic signed [ppp_pkg::OFS_W-1:0]    offset
);

	localparam int ITER_W = $clog2(ppp_pkg::QUO_W);

	logic                        busy_q;
	logic                        fin_q;
	logic                        done_q;
	logic [ITER_W-1:0]           cnt_q;
	logic [ppp_pkg::PROD_W-1:0]  rem_q;
	logic [ppp_pkg::QUO_W-1:0]   shf_q;
	logic [ppp_pkg::QUO_W-1:0]   quo_q;
	logic                        neg_q;
	logic signed [ppp_pkg::OFS_W-1:0] offset_q;

	logic [ppp_pkg::PROD_W-1:0]  rem_shift;
	logic [ppp_pkg::PROD_W:0]    rem_diff;
	logic                        rem_ge;
	logic [ppp_pkg::PROD_W-1:0]  rem_twice;
	logic                        round_up;
	logic [ppp_pkg::OFS_W-1:0]   mag;

	// remainder stays below den, so its top bit is always clear
	assign rem_shift = {rem_q[ppp_pkg::PROD_W-2:0], shf_q[ppp_pkg::QUO_W-1]};
	assign rem_diff  = {1'b0, rem_shift} - {1'b0, den};
	assign rem_ge    = ~rem_diff[ppp_pkg::PROD_W];
	assign rem_twice = {rem_q[ppp_pkg::PROD_W-2:0], 1'b0};
	// exact half rounds away from zero for positive, toward zero for negative
	assign round_up  = neg_q ? (rem_twice > den) : (rem_twice >= den);
	assign mag       = {1'b0, quo_q} + ppp_pkg::OFS_W'(round_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(ppp_pkg::QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - ITER_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_hi;
			shf_q <= num_lo;
			quo_q <= '0;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= rem_ge ? rem_diff[ppp_pkg::PROD_W-1:0] : rem_shift;
			shf_q <= {shf_q[ppp_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[ppp_pkg::QUO_W-2:0], rem_ge};
		end
		if (fin_q) begin
			offset_q <= neg_q ? $signed(ppp_pkg::OFS_W'(-mag)) : $signed(mag);
		end
	end

	assign rsp.busy = busy_q | fin_q;
	assign rsp.done = done_q;
	assign offset   = offset_q;

endmodule

FILE: sv/polyline_point_projection_core.sv
// ----------------------------------------------------------------------------
// polyline_point_projection_core: closest point on a polyline, one vertex per transfer
// A first vertex or a dropped vertex goes straight to the finish step, a segment
// whose foot is not tested runs the multiplier steps and the check, and a foot
// test adds two 32-step passes of the shared restoring divider. The result
// enters the output register when the last vertex is done. Reset clears the
// sequencer, the best candidate, the previous vertex and the vertex count at once.
// ----------------------------------------------------------------------------
module polyline_point_projection_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// query_x, query_y, vertex_x, vertex_y (from bit 0 up), zero padded
	input  logic [ppp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// first_vertex
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// proj_x, proj_y, segment_index (from bit 0 up), zero padded
	output logic [ppp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// index_valid
	output logic                               m_axis_tuser
);

	localparam int C      = ppp_pkg::COORD_BITS;
	localparam int PT_W   = ppp_pkg::PT_W;
	localparam int DIFF_W = ppp_pkg::DIFF_W;
	localparam int PROD_W = ppp_pkg::PROD_W;
	localparam int MAG_W  = ppp_pkg::MAG_W;
	localparam int STEP_W = 4;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_CHK   = 7'b0000100,
		ST_FMUL  = 7'b0001000,
		ST_FDIV  = 7'b0010000,
		ST_FDIST = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	// multiplier issue steps and the steps that take the returned products
	localparam logic [STEP_W-1:0] MS_DS_X  = 4'd0;
	localparam logic [STEP_W-1:0] MS_DS_Y  = 4'd1;
	localparam logic [STEP_W-1:0] MS_DE_X  = 4'd2;
	localparam logic [STEP_W-1:0] MS_DE_Y  = 4'd3;
	localparam logic [STEP_W-1:0] MS_LEN_X = 4'd4;
	localparam logic [STEP_W-1:0] MS_LEN_Y = 4'd5;
	localparam logic [STEP_W-1:0] MS_DOT_X = 4'd6;
	localparam logic [STEP_W-1:0] MS_DOT_Y = 4'd7;
	localparam logic [STEP_W-1:0] MC_START = 4'd3;
	localparam logic [STEP_W-1:0] MC_END   = 4'd5;
	localparam logic [STEP_W-1:0] MC_LEN   = 4'd7;
	localparam logic [STEP_W-1:0] MC_DOT   = 4'd9;
	localparam logic [STEP_W-1:0] FM_LO    = 4'd0;
	localparam logic [STEP_W-1:0] FM_TAKE_LO = 4'd2;
	localparam logic [STEP_W-1:0] FM_TAKE_HI = 4'd3;
	localparam logic [STEP_W-1:0] FD_TAKE  = 4'd3;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic                       axis_q;
	logic                       last_q;
	logic                       take_q;
	logic [ppp_pkg::CNT_W-1:0]  count_q;

	logic signed [PT_W-1:0]     qx_q, qy_q, vx_q, vy_q;
	logic signed [PT_W-1:0]     prev_x_q, prev_y_q;
	logic signed [PT_W-1:0]     foot_x_q, foot_y_q;

	logic [PROD_W-1:0]          best_dist_q;
	logic [C-1:0]               best_x_q, best_y_q;
	logic [ppp_pkg::IDX_W-1:0]  best_idx_q;
	logic                       best_found_q;

	logic [PROD_W-1:0]          acc_q, d_q, p_q, lo_q;

	logic                       m_valid_q;
	logic [C-1:0]               out_x_q, out_y_q;
	logic [ppp_pkg::IDX_W-1:0]  out_idx_q;
	logic                       out_iv_q;

	logic                       accept;
	logic                       start_new;
	logic [ppp_pkg::CNT_W-1:0]  cnt_eff;
	logic                       take_in;
	logic                       seg_in;
	logic                       out_free;
	logic                       load_out;
	logic                       foot_ok;

	logic signed [PT_W-1:0]     a1, b1, a2, b2;
	logic signed [DIFF_W-1:0]   diff1, diff2;
	logic signed [DIFF_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0]          mul_prod;
	logic                       mul_neg;
	logic [PROD_W-1:0]          acc_in;
	logic [PROD_W-1:0]          sum;

	logic                       cons_en;
	logic [C-1:0]               cand_x, cand_y;
	logic [ppp_pkg::IDX_W-1:0]  cand_idx;
	logic [ppp_pkg::IDX_W-1:0]  seg_idx;

	ppp_pkg::ppp_div_req_t      div_req;
	ppp_pkg::ppp_div_rsp_t      div_rsp;
	logic [PROD_W-1:0]          div_num_hi;
	logic signed [ppp_pkg::OFS_W-1:0] div_offset;
	logic signed [DIFF_W-1:0]   foot_sum;
	logic signed [PT_W-1:0]     foot_base;

	assign accept        = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// a vertex with no polyline open starts one even without the first mark
	assign start_new = s_axis_tuser | (count_q == '0);
	assign cnt_eff   = start_new ? '0 : count_q;
	assign take_in   = (cnt_eff < ppp_pkg::CNT_W'(ppp_pkg::MAX_VERTICES));
	assign seg_in    = take_in & (cnt_eff != '0);

	assign out_free  = ~m_valid_q | m_axis_tready;
	assign load_out  = (state_q == ST_FIN) & last_q & out_free;

	assign foot_ok = (d_q != '0) & ~p_q[PROD_W-1] & (p_q != '0) & (p_q < d_q);

	// operand selection for the shared multiplier
	always_comb begin
		a1 = qx_q;
		b1 = qx_q;
		a2 = qx_q;
		b2 = qx_q;
		if (state_q == ST_MUL) begin
			case (step_q)
				MS_DS_X:  begin a1 = prev_x_q; b1 = qx_q; a2 = prev_x_q; b2 = qx_q; end
				MS_DS_Y:  begin a1 = prev_y_q; b1 = qy_q; a2 = prev_y_q; b2 = qy_q; end
				MS_DE_X:  begin a1 = vx_q; b1 = qx_q; a2 = vx_q; b2 = qx_q; end
				MS_DE_Y:  begin a1 = vy_q; b1 = qy_q; a2 = vy_q; b2 = qy_q; end
				MS_LEN_X: begin a1 = vx_q; b1 = prev_x_q; a2 = vx_q; b2 = prev_x_q; end
				MS_LEN_Y: begin a1 = vy_q; b1 = prev_y_q; a2 = vy_q; b2 = prev_y_q; end
				MS_DOT_X: begin a1 = vx_q; b1 = prev_x_q; a2 = qx_q; b2 = prev_x_q; end
				MS_DOT_Y: begin a1 = vy_q; b1 = prev_y_q; a2 = qy_q; b2 = prev_y_q; end
				default:  begin a1 = qx_q; b1 = qx_q; a2 = qx_q; b2 = qx_q; end
			endcase
		end else if (state_q == ST_FMUL) begin
			a2 = axis_q ? vy_q : vx_q;
			b2 = axis_q ? prev_y_q : prev_x_q;
		end else if (state_q == ST_FDIST) begin
			a1 = step_q[0] ? foot_y_q : foot_x_q;
			b1 = step_q[0] ? qy_q : qx_q;
			a2 = a1;
			b2 = b1;
		end
	end

	assign diff1 = {a1[PT_W-1], a1} - {b1[PT_W-1], b1};
	assign diff2 = {a2[PT_W-1], a2} - {b2[PT_W-1], b2};

	// foot: split the dot product into halves against the segment delta
	assign mul_a = (state_q != ST_FMUL) ? diff1 :
		(step_q == FM_LO) ? $signed({1'b0, p_q[MAG_W-1:0]}) :
		$signed({1'b0, p_q[PROD_W-1:MAG_W]});
	assign mul_b = diff2;

	ppp_mul u_mul (
		.clk  (clk),
		.opa  (mul_a),
		.opb  (mul_b),
		.prod (mul_prod),
		.neg  (mul_neg)
	);

	// odd steps finish a two-term sum, even steps start one
	assign acc_in = step_q[0] ? acc_q : '0;
	assign sum    = acc_in + (mul_prod ^ {PROD_W{mul_neg}}) + PROD_W'(mul_neg);

	assign seg_idx = count_q[ppp_pkg::IDX_W-1:0] - ppp_pkg::IDX_W'(1);

	always_comb begin
		cons_en  = 1'b0;
		cand_x   = prev_x_q[C-1:0];
		cand_y   = prev_y_q[C-1:0];
		cand_idx = seg_idx;
		if (state_q == ST_MUL && step_q == MC_START) begin
			cons_en = 1'b1;
		end else if (state_q == ST_MUL && step_q == MC_END) begin
			cons_en  = 1'b1;
			cand_x   = vx_q[C-1:0];
			cand_y   = vy_q[C-1:0];
			cand_idx = count_q[ppp_pkg::IDX_W-1:0];
		end else if (state_q == ST_FDIST && step_q == FD_TAKE) begin
			cons_en = 1'b1;
			cand_x  = foot_x_q[C-1:0];
			cand_y  = foot_y_q[C-1:0];
		end
	end

	assign div_req.start = (state_q == ST_FMUL) & (step_q == FM_TAKE_HI);
	assign div_req.neg   = diff2[DIFF_W-1];
	assign div_num_hi    = mul_prod + {{MAG_W{1'b0}}, lo_q[PROD_W-1:MAG_W]};

	ppp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num_hi (div_num_hi),
		.num_lo (lo_q[MAG_W-1:0]),
		.den    (d_q),
		.rsp    (div_rsp),
		.offset (div_offset)
	);

	assign foot_base = axis_q ? prev_y_q : prev_x_q;
	assign foot_sum  = {foot_base[PT_W-1], foot_base} + div_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			axis_q       <= 1'b0;
			last_q       <= 1'b0;
			take_q       <= 1'b0;
			count_q      <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			best_dist_q  <= '1;
			best_x_q     <= '0;
			best_y_q     <= '0;
			best_idx_q   <= '0;
			best_found_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && !load_out) begin
				m_valid_q <= 1'b0;
			end
			// strict compare: earlier candidates keep ties
			if (cons_en && (sum < best_dist_q)) begin
				best_dist_q  <= sum;
				best_x_q     <= cand_x;
				best_y_q     <= cand_y;
				best_idx_q   <= cand_idx;
				best_found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= s_axis_tlast;
						take_q <= take_in;
						step_q <= '0;
						if (start_new) begin
							count_q      <= '0;
							best_dist_q  <= '1;
							best_x_q     <= '0;
							best_y_q     <= '0;
							best_idx_q   <= '0;
							best_found_q <= 1'b0;
						end
						state_q <= seg_in ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == MC_DOT) begin
						step_q  <= '0;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					axis_q  <= 1'b0;
					step_q  <= '0;
					state_q <= foot_ok ? ST_FMUL : ST_FIN;
				end
				ST_FMUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == FM_TAKE_HI) begin
						state_q <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (div_rsp.done) begin
						step_q <= '0;
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= ST_FMUL;
						end else begin
							state_q <= ST_FDIST;
						end
					end
				end
				ST_FDIST: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == FD_TAKE) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold while an earlier result still waits for its transfer
					if (!last_q || out_free) begin
						if (take_q) begin
							prev_x_q <= vx_q;
							prev_y_q <= vy_q;
						end
						if (last_q) begin
							count_q   <= '0;
							m_valid_q <= 1'b1;
						end else if (take_q) begin
							count_q <= count_q + ppp_pkg::CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= {s_axis_tdata[C-1], s_axis_tdata[C-1:0]};
			qy_q <= {s_axis_tdata[2*C-1], s_axis_tdata[2*C-1:C]};
			vx_q <= {s_axis_tdata[3*C-1], s_axis_tdata[3*C-1:2*C]};
			vy_q <= {s_axis_tdata[4*C-1], s_axis_tdata[4*C-1:3*C]};
		end
		acc_q <= sum;
		if (state_q == ST_MUL && step_q == MC_LEN) begin
			d_q <= sum;
		end
		if (state_q == ST_MUL && step_q == MC_DOT) begin
			p_q <= sum;
		end
		if (state_q == ST_FMUL && step_q == FM_TAKE_LO) begin
			lo_q <= mul_prod;
		end
		if (state_q == ST_FDIV && div_rsp.done) begin
			if (axis_q) begin
				foot_y_q <= foot_sum[PT_W-1:0];
			end else begin
				foot_x_q <= foot_sum[PT_W-1:0];
			end
		end
		if (load_out) begin
			out_x_q   <= best_found_q ? best_x_q : qx_q[C-1:0];
			out_y_q   <= best_found_q ? best_y_q : qy_q[C-1:0];
			out_idx_q <= best_found_q ? best_idx_q : '0;
			out_iv_q  <= best_found_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{ppp_pkg::OUT_PAD_W{1'b0}}, out_idx_q, out_y_q, out_x_q};
	assign m_axis_tuser  = out_iv_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_FDIV))
		else $error("divider result outside the divide wait");

	a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FDIV && !div_rsp.done) |-> div_rsp.busy)
		else $error("sequencer waits on an idle divider");

	a_foot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FMUL) |-> (!p_q[PROD_W-1] && p_q != '0 && p_q < d_q))
		else $error("foot computed with dot product out of range");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside the finish step");

endmodule
